// ===== sv/tsrp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrp_pkg: shared types and constants of the task scheduler
// Table geometry, state and mode codes, the table entry layout and the
// write-port bundle between the sequencer and the task table.
// ----------------------------------------------------------------------------
package tsrp_pkg;

  // Table geometry
  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 48;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int PRIO_W    = 8;
  localparam int RUNS_W    = 32;
  localparam int ACT_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int BEST_W    = 10;

  // Priority accumulator start value, above any real priority
  localparam logic [BEST_W-1:0] NO_PRIORITY = BEST_W'(999);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_DEAD    = 2'd3
  } task_state_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_YIELD = 2'd1,
    MODE_SLEEP = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_t;

  // One task table entry
  typedef struct packed {
    task_state_t           state;
    logic [PRIO_W-1:0]     prio;
    logic [TIME_BITS-1:0]  wake;
    logic [RUNS_W-1:0]     runs;
  } entry_t;

  // Table write port with per-field enables
  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      addr;
    logic                  we_state;
    logic                  we_prio;
    logic                  we_wake;
    logic                  we_runs;
    entry_t                data;
  } tbl_wr_t;

endpackage

// ===== sv/tsrp_table.sv =====
// ----------------------------------------------------------------------------
// tsrp_table: task entry memory
// Synchronous memory of task entries with one read and one write port.
// Read data is registered (old data on a same-address
// write). Per-entry valid bits make never-written entries read as the
// reset entry: dead, priority, wake time and run count zero.
// ----------------------------------------------------------------------------
module tsrp_table (
  input  logic                           clk,
  input  logic                           rst,
  input  tsrp_pkg::tbl_wr_t              wr,
  input  logic [tsrp_pkg::IDX_W-1:0]     rd_addr,
  output tsrp_pkg::entry_t               rd_data
);

  tsrp_pkg::task_state_t                 mem_state [tsrp_pkg::MAX_TASKS];
  logic [tsrp_pkg::PRIO_W-1:0]           mem_prio  [tsrp_pkg::MAX_TASKS];
  logic [tsrp_pkg::TIME_BITS-1:0]        mem_wake  [tsrp_pkg::MAX_TASKS];
  logic [tsrp_pkg::RUNS_W-1:0]           mem_runs  [tsrp_pkg::MAX_TASKS];
  logic [tsrp_pkg::MAX_TASKS-1:0]        valid;

  tsrp_pkg::entry_t                      rd_q;
  logic                                  rd_valid_q;

  // Valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // Field writes; a first write to an entry fills the other fields with reset values
  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.we_state || !valid[wr.addr]) begin
        mem_state[wr.addr] <= wr.we_state ? wr.data.state : tsrp_pkg::ST_DEAD;
      end
      if (wr.we_prio || !valid[wr.addr]) begin
        mem_prio[wr.addr] <= wr.we_prio ? wr.data.prio : '0;
      end
      if (wr.we_wake || !valid[wr.addr]) begin
        mem_wake[wr.addr] <= wr.we_wake ? wr.data.wake : '0;
      end
      if (wr.we_runs || !valid[wr.addr]) begin
        mem_runs[wr.addr] <= wr.we_runs ? wr.data.runs : '0;
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_q.state <= mem_state[rd_addr];
    rd_q.prio  <= mem_prio[rd_addr];
    rd_q.wake  <= mem_wake[rd_addr];
    rd_q.runs  <= mem_runs[rd_addr];
    rd_valid_q <= valid[rd_addr];
  end

  // Unwritten entries read as the reset entry
  always_comb begin
    if (rd_valid_q) begin
      rd_data = rd_q;
    end else begin
      rd_data       = '0;
      rd_data.state = tsrp_pkg::ST_DEAD;
    end
  end

endmodule

// ===== sv/task_scheduler_rr_priority_core.sv =====
// ----------------------------------------------------------------------------
// task_scheduler_rr_priority_core: round-robin / fixed-priority scheduler
// Sequencer over a task table memory: wakes due sleepers, picks the next
// task by policy, switches and counts runs, and loads entries; one result per transaction.
// ----------------------------------------------------------------------------
// One input transaction is handled at a time; in_stall is high until its
// result is placed in the output register. A load, and a sleep with no
// current task, go straight to the result. A tick or yield first reduces
// the round-robin start index modulo n, the number of entries in use, by
// repeated subtraction (at most 16 / n subtractions, so 0 or 1 with all 16
// entries in use); a sleep with a current task first writes its entry. The
// single table read port sets the order: one pass reads every entry in
// use, waking and selecting in the same pass, then the old and the new
// task are read back and written when it switches tasks. With no entries
// in use a tick or yield skips the pass. The table needs no clearing pass
// after reset. A finished result may wait in the output register while
// the next transaction is accepted.
// ----------------------------------------------------------------------------
module task_scheduler_rr_priority_core (
  input  logic                               clk,
  input  logic                               rst,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         mode,
  input  logic [47:0]                        now_ms,
  input  logic [47:0]                        sleep_ms,
  input  logic [3:0]                         task_index,
  input  logic [7:0]                         task_priority,
  input  logic [1:0]                         task_state,
  // Output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               switched,
  output logic                               running_valid,
  output logic [3:0]                         running_task,
  output logic [3:0]                         previous_task,
  output logic                               previous_valid,
  output logic [31:0]                        run_count,
  output logic [31:0]                        tick_total,
  // Configuration
  input  logic                               cfg_write,
  input  logic [tsrp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsrp_pkg::ACT_W-1:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLEEP,
    S_PREP,
    S_SCAN,
    S_OLD_RD,
    S_OLD_WR,
    S_NEW_WR,
    S_DONE
  } fsm_t;

  localparam int IW = tsrp_pkg::IDX_W;
  localparam int CW = tsrp_pkg::CNT_W;
  localparam int TB = tsrp_pkg::TIME_BITS;

  fsm_t                         state;

  // Configuration registers
  logic                         policy;
  logic [tsrp_pkg::ACT_W-1:0]   active;

  // Scheduler state
  logic [IW-1:0]                cur;
  logic                         cur_valid;
  logic [tsrp_pkg::RUNS_W-1:0]  cur_runs;
  logic [31:0]                  tick_counter;

  // Captured transaction
  logic [TB-1:0]                now_r;
  logic [TB-1:0]                sleep_r;

  // Scan bookkeeping
  logic [CW-1:0]                rr_start;
  logic [CW-1:0]                scan_cnt;
  logic                         first_found;
  logic [IW-1:0]                first_idx;
  logic                         ge_found;
  logic [IW-1:0]                ge_idx;
  logic [tsrp_pkg::BEST_W-1:0]  pr_best;
  logic [IW-1:0]                pr_idx;
  logic [IW-1:0]                pick_r;

  // Result flags
  logic                         sw_r;
  logic                         pv_r;
  logic [IW-1:0]                pt_r;

  // Table ports
  tsrp_pkg::tbl_wr_t            tbl_wr;
  logic [IW-1:0]                rd_addr;
  tsrp_pkg::entry_t             rd_data;

  // Combinational helpers
  logic [CW-1:0]                n_used;
  logic [CW-1:0]                rr_base1;
  logic [IW-1:0]                scan_idx;
  logic                         scan_last;
  logic                         wake_hit;
  logic                         runnable;
  logic                         pick_found;
  logic [IW-1:0]                pick;
  logic [TB:0]                  wake_sum;
  logic [TB-1:0]                wake_sat;
  logic [tsrp_pkg::RUNS_W-1:0]  new_runs;
  logic                         load_ok;

  tsrp_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != S_IDLE);

  // Entries in use, clamped to the table size
  assign n_used = (int'(active) > tsrp_pkg::MAX_TASKS) ? CW'(tsrp_pkg::MAX_TASKS)
                                                       : CW'(active);

  // Round-robin start before the modulo: one past the current task, or n without one
  assign rr_base1 = (cur_valid ? CW'(cur) : (n_used - CW'(1))) + CW'(1);

  assign scan_idx  = scan_cnt[IW-1:0];
  assign scan_last = (scan_cnt == (n_used - CW'(1)));

  // Wake check and runnable test on the entry being scanned
  assign wake_hit = (rd_data.state == tsrp_pkg::ST_BLOCKED) && (rd_data.wake <= now_r);
  assign runnable = wake_hit || (rd_data.state == tsrp_pkg::ST_READY) ||
                    (rd_data.state == tsrp_pkg::ST_RUNNING);

  // Final pick by policy
  assign pick_found = policy ? (pr_best != tsrp_pkg::NO_PRIORITY) : first_found;
  assign pick       = policy ? pr_idx : (ge_found ? ge_idx : first_idx);

  // Saturating wake time for sleep
  assign wake_sum = {1'b0, now_r} + {1'b0, sleep_r};
  assign wake_sat = wake_sum[TB] ? {TB{1'b1}} : wake_sum[TB-1:0];

  // Saturating run count of the task switched in
  assign new_runs = (&rd_data.runs) ? rd_data.runs : rd_data.runs + 1'b1;

  assign load_ok = (int'(task_index) < tsrp_pkg::MAX_TASKS);

  // Table read address
  always_comb begin
    case (state)
      S_PREP:   rd_addr = '0;
      S_SCAN:   rd_addr = scan_idx + 1'b1;
      S_OLD_RD: rd_addr = cur;
      S_OLD_WR: rd_addr = pick_r;
      default:  rd_addr = cur;
    endcase
  end

  // Table write port
  always_comb begin
    tbl_wr = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && (tsrp_pkg::mode_t'(mode) == tsrp_pkg::MODE_LOAD) && load_ok) begin
          tbl_wr.en         = 1'b1;
          tbl_wr.addr       = task_index[IW-1:0];
          tbl_wr.we_state   = 1'b1;
          tbl_wr.we_prio    = 1'b1;
          tbl_wr.data.state = tsrp_pkg::task_state_t'(task_state);
          tbl_wr.data.prio  = task_priority;
        end
      end
      S_SLEEP: begin
        tbl_wr.en         = 1'b1;
        tbl_wr.addr       = cur;
        tbl_wr.we_state   = 1'b1;
        tbl_wr.we_wake    = 1'b1;
        tbl_wr.data.state = tsrp_pkg::ST_BLOCKED;
        tbl_wr.data.wake  = wake_sat;
      end
      S_SCAN: begin
        if (wake_hit) begin
          tbl_wr.en         = 1'b1;
          tbl_wr.addr       = scan_idx;
          tbl_wr.we_state   = 1'b1;
          tbl_wr.we_wake    = 1'b1;
          tbl_wr.data.state = tsrp_pkg::ST_READY;
          tbl_wr.data.wake  = '0;
        end
      end
      S_OLD_WR: begin
        if (cur_valid && (rd_data.state == tsrp_pkg::ST_RUNNING)) begin
          tbl_wr.en         = 1'b1;
          tbl_wr.addr       = cur;
          tbl_wr.we_state   = 1'b1;
          tbl_wr.data.state = tsrp_pkg::ST_READY;
        end
      end
      S_NEW_WR: begin
        tbl_wr.en         = 1'b1;
        tbl_wr.addr       = pick_r;
        tbl_wr.we_state   = 1'b1;
        tbl_wr.we_runs    = 1'b1;
        tbl_wr.data.state = tsrp_pkg::ST_RUNNING;
        tbl_wr.data.runs  = new_runs;
      end
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 1'b0;
      active <= '0;
    end else if (cfg_write) begin
      if (cfg_index == tsrp_pkg::REG_POLICY) begin
        policy <= cfg_data[0];
      end else if (cfg_index == tsrp_pkg::REG_ACTIVE) begin
        active <= cfg_data;
      end
    end
  end

  // Sequencer, scheduler state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur          <= '0;
      cur_valid    <= 1'b0;
      cur_runs     <= '0;
      tick_counter <= '0;
      out_valid    <= 1'b0;
      sw_r         <= 1'b0;
      pv_r         <= 1'b0;
      pt_r         <= '0;
    end else begin
      // S_DONE refills the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            now_r    <= now_ms;
            sleep_r  <= sleep_ms;
            sw_r     <= 1'b0;
            pv_r     <= 1'b0;
            pt_r     <= '0;
            rr_start <= rr_base1;
            case (tsrp_pkg::mode_t'(mode))
              tsrp_pkg::MODE_TICK: begin
                tick_counter <= tick_counter + 1'b1;
                state        <= S_PREP;
              end
              tsrp_pkg::MODE_YIELD: state <= S_PREP;
              tsrp_pkg::MODE_SLEEP: state <= cur_valid ? S_SLEEP : S_DONE;
              default:              state <= S_DONE;
            endcase
          end
        end
        S_SLEEP: begin
          state <= S_PREP;
        end
        // Reduce the round-robin start modulo n, then open the scan
        S_PREP: begin
          if (n_used == '0) begin
            state <= S_DONE;
          end else if (rr_start >= n_used) begin
            rr_start <= rr_start - n_used;
          end else begin
            scan_cnt    <= '0;
            first_found <= 1'b0;
            ge_found    <= 1'b0;
            pr_best     <= tsrp_pkg::NO_PRIORITY;
            state       <= S_SCAN;
          end
        end
        // One entry per cycle: wake and track the candidates of both policies
        S_SCAN: begin
          if (runnable && !first_found) begin
            first_found <= 1'b1;
            first_idx   <= scan_idx;
          end
          if (runnable && !ge_found && (scan_cnt >= rr_start)) begin
            ge_found <= 1'b1;
            ge_idx   <= scan_idx;
          end
          if (runnable && ({2'b00, rd_data.prio} < pr_best)) begin
            pr_best <= {2'b00, rd_data.prio};
            pr_idx  <= scan_idx;
          end
          if (scan_last) begin
            state <= S_OLD_RD;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_OLD_RD: begin
          if (!pick_found || (cur_valid && (pick == cur))) begin
            state <= S_DONE;
          end else begin
            pick_r <= pick;
            state  <= S_OLD_WR;
          end
        end
        S_OLD_WR: begin
          state <= S_NEW_WR;
        end
        S_NEW_WR: begin
          sw_r      <= 1'b1;
          pv_r      <= cur_valid;
          pt_r      <= cur_valid ? cur : '0;
          cur       <= pick_r;
          cur_valid <= 1'b1;
          cur_runs  <= new_runs;
          state     <= S_DONE;
        end
        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            switched       <= sw_r;
            running_valid  <= cur_valid;
            running_task   <= cur_valid ? 4'(cur) : 4'd0;
            previous_task  <= pv_r ? 4'(pt_r) : 4'd0;
            previous_valid <= sw_r && pv_r;
            run_count      <= cur_valid ? cur_runs : 32'd0;
            tick_total     <= tick_counter;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
